// File: src/fpcc_pkg.sv
// Shared types, field widths and the CRC-16/CCITT byte update for the
// flash page commit checker. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fpcc_pkg;

    // Field and register widths
    localparam int SIZE_W   = 25;  // image_size / slot_size
    localparam int BYTE_W   = 8;
    localparam int PNUM_W   = 16;  // page_number
    localparam int CRC_W    = 16;
    localparam int STATUS_W = 3;
    localparam int WOFF_W   = 24;  // write_offset
    localparam int PAGES_W  = 17;  // pages_done / expected page
    localparam int CFG_IDX_W = 1;

    // Stream tdata widths (packed fields padded to whole bytes)
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    // CRC-16/CCITT-FALSE
    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
    localparam logic [CRC_W-1:0] CRC_TOP  = 16'h8000;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_NOT_STARTED = 3'd1,
        ST_BOUNDS      = 3'd2,
        ST_SEQ         = 3'd3,
        ST_CRC         = 3'd4
    } t_status;

    typedef enum logic {
        OP_START = 1'b0,
        OP_DATA  = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_SIZE = 1'b0,
        REG_SLOT_SIZE  = 1'b1
    } t_reg_idx;

    // One byte into the CRC, MSB first, eight shift steps
    function automatic logic [CRC_W-1:0] crc16_feed(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] din);
        logic [CRC_W-1:0] c;
        c = crc ^ {din, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != '0) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: src/flash_page_commit_checker.sv
// Flash page commit checker: session start, per-page byte count and CRC-16,
// ordered page checks. Depends on fpcc_pkg.
//
//  channel   | dir | handshake                      | payload
//  ----------+-----+--------------------------------+----------------------------------
//  s_axis    | in  | i_s_axis_tvalid/o_s_axis_tready | tdata: data_byte, page_number,
//            |     |                                 | page_crc; tlast: last_byte; tuser: op
//  m_axis    | out | o_m_axis_tvalid/i_m_axis_tready | tdata: status, write_offset, pages_done
//  cfg       | in  | i_cfg_we                        | i_cfg_index, i_cfg_data
//
// One item per cycle unless the output stalls: an item waits in the input
// register, then the CRC update and page checks run in one pass into the state
// and result registers, so a result passes the input register, then the result register.
// Only items that produce a result (start, last byte) wait on a stalled output;
// other bytes keep flowing. Reset is synchronous, active low, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module flash_page_commit_checker
    import fpcc_pkg::*;
#(
    parameter int PAGE_BYTES = 256
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Input stream
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // [7:0] data_byte, [23:8] page_number, [39:24] page_crc
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input  wire logic                   i_s_axis_tlast,   // last_byte
    input  wire logic                   i_s_axis_tuser,   // op
    // Result stream
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // [2:0] status, [26:3] write_offset, [43:27] pages_done, [47:44] zero
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,
    // Configuration writes
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [SIZE_W-1:0]      i_cfg_data
);

    // Byte count saturates at PAGE_BYTES + 1
    localparam int CNT_W = $clog2(PAGE_BYTES + 2);
    // Running page offset covers expected pages up to 2^PAGES_W - 1
    localparam int OFF_W = PAGES_W + $clog2(PAGE_BYTES);
    localparam int CMP_W = (OFF_W > SIZE_W) ? OFF_W : SIZE_W;
    localparam logic [CNT_W-1:0] PB_CNT   = CNT_W'(PAGE_BYTES);
    localparam logic [CNT_W-1:0] PB_CNT_1 = CNT_W'(PAGE_BYTES + 1);
    localparam logic [OFF_W-1:0] PB_OFF   = OFF_W'(PAGE_BYTES);
    localparam logic [CMP_W-1:0] PB_CMP   = CMP_W'(PAGE_BYTES);

    // Configuration registers
    logic [SIZE_W-1:0] r_image_size;
    logic [SIZE_W-1:0] r_slot_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size <= '0;
            r_slot_size  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_IMAGE_SIZE: r_image_size <= i_cfg_data;
                REG_SLOT_SIZE:  r_slot_size  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    logic              r_s1_valid;
    t_op               r_s1_op;
    logic              r_s1_last;
    logic [BYTE_W-1:0] r_s1_byte;
    logic [PNUM_W-1:0] r_s1_page;
    logic [CRC_W-1:0]  r_s1_crc;

    // Session state
    logic               r_session_open;
    logic [PAGES_W-1:0] r_exp_page;
    logic [OFF_W-1:0]   r_page_off;   // r_exp_page * PAGE_BYTES
    logic [CRC_W-1:0]   r_run_crc;
    logic [CNT_W-1:0]   r_byte_cnt;

    // Result register
    logic               r_m_valid;
    t_status            r_m_status;
    logic [WOFF_W-1:0]  r_m_woff;
    logic [PAGES_W-1:0] r_m_pages;

    // Handshake
    logic s1_has_result;
    logic out_free;
    logic s1_fire;
    logic s_accept;
    logic m_load;

    assign s1_has_result   = (r_s1_op == OP_START) || r_s1_last;
    assign out_free        = !r_m_valid || i_m_axis_tready;
    assign s1_fire         = r_s1_valid && (!s1_has_result || out_free);
    assign o_s_axis_tready = !r_s1_valid || s1_fire;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign m_load          = s1_fire && s1_has_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_s1_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_op   <= t_op'(i_s_axis_tuser);
            r_s1_last <= i_s_axis_tlast;
            r_s1_byte <= i_s_axis_tdata[7:0];
            r_s1_page <= i_s_axis_tdata[23:8];
            r_s1_crc  <= i_s_axis_tdata[39:24];
        end
    end

    // Per-item processing
    logic               n_session_open;
    logic [PAGES_W-1:0] n_exp_page;
    logic [OFF_W-1:0]   n_page_off;
    logic [CRC_W-1:0]   n_run_crc;
    logic [CNT_W-1:0]   n_byte_cnt;
    t_status            n_m_status;
    logic [WOFF_W-1:0]  n_m_woff;

    logic [CRC_W-1:0] crc_upd;
    logic [CNT_W-1:0] cnt_upd;
    logic [CMP_W-1:0] off_ext;
    logic [CMP_W-1:0] img_ext;
    logic [CMP_W-1:0] slot_ext;
    logic [CMP_W-1:0] remaining;
    logic             len_ok;
    t_status          page_status;

    always_comb begin
        crc_upd   = crc16_feed(r_run_crc, r_s1_byte);
        cnt_upd   = (r_byte_cnt <= PB_CNT) ? r_byte_cnt + 1'b1 : r_byte_cnt;
        off_ext   = CMP_W'(r_page_off);
        img_ext   = CMP_W'(r_image_size);
        slot_ext  = CMP_W'(r_slot_size);
        remaining = img_ext - off_ext;
        len_ok    = (remaining >= PB_CMP) ? (cnt_upd == PB_CNT)
                                          : (cnt_upd == remaining[CNT_W-1:0]);

        // Checks in priority order
        if (!r_session_open) begin
            page_status = ST_NOT_STARTED;
        end else if (cnt_upd == '0 || cnt_upd == PB_CNT_1) begin
            page_status = ST_BOUNDS;
        end else if ({1'b0, r_s1_page} != r_exp_page) begin
            page_status = ST_SEQ;
        end else if (off_ext >= img_ext || off_ext >= slot_ext || !len_ok) begin
            page_status = ST_BOUNDS;
        end else if (crc_upd != r_s1_crc) begin
            page_status = ST_CRC;
        end else begin
            page_status = ST_OK;
        end
    end

    always_comb begin
        n_session_open = r_session_open;
        n_exp_page     = r_exp_page;
        n_page_off     = r_page_off;
        n_run_crc      = r_run_crc;
        n_byte_cnt     = r_byte_cnt;
        n_m_status     = ST_OK;
        n_m_woff       = '0;
        if (r_s1_op == OP_START) begin
            if (r_image_size == '0 || r_image_size > r_slot_size) begin
                n_m_status = ST_BOUNDS;
            end else begin
                n_session_open = 1'b1;
                n_exp_page     = '0;
                n_page_off     = '0;
                n_run_crc      = CRC_INIT;
                n_byte_cnt     = '0;
            end
        end else if (r_s1_last) begin
            n_m_status = page_status;
            n_run_crc  = CRC_INIT;
            n_byte_cnt = '0;
            if (page_status == ST_OK) begin
                n_exp_page = r_exp_page + 1'b1;
                n_page_off = r_page_off + PB_OFF;
                n_m_woff   = WOFF_W'(r_page_off);
            end
        end else begin
            n_run_crc  = crc_upd;
            n_byte_cnt = cnt_upd;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_session_open <= 1'b0;
            r_exp_page     <= '0;
            r_page_off     <= '0;
            r_run_crc      <= CRC_INIT;
            r_byte_cnt     <= '0;
        end else if (s1_fire) begin
            r_session_open <= n_session_open;
            r_exp_page     <= n_exp_page;
            r_page_off     <= n_page_off;
            r_run_crc      <= n_run_crc;
            r_byte_cnt     <= n_byte_cnt;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (m_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_load) begin
            r_m_status <= n_m_status;
            r_m_woff   <= n_m_woff;
            r_m_pages  <= n_exp_page;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {4'b0000, r_m_pages, r_m_woff, r_m_status};

    // Assertions
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_load && r_m_valid) |-> i_m_axis_tready)
        else $error("result overwritten before it was taken");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_cnt <= PB_CNT_1)
        else $error("page byte count beyond saturation");

    a_off_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_page_off == OFF_W'(r_exp_page * PAGE_BYTES))
        else $error("page offset out of step with expected page");

    a_closed_page0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_session_open |-> (r_exp_page == '0))
        else $error("pages advanced without a session");

    a_woff_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_status != ST_OK) |-> (r_m_woff == '0))
        else $error("nonzero write offset on a failed item");

endmodule

`default_nettype wire
